// ===== rtl/b2da_pkg.sv =====
// Shared types, constants and the double-dabble step function for the decimal text converter.
package b2da_pkg;

    localparam int VALUE_W         = 32;
    localparam int DIGITS          = 10;
    localparam int BCD_W           = 4 * DIGITS;
    localparam int IDX_W           = $clog2(DIGITS);
    localparam int CHAR_W          = 6;
    localparam int STEPS_PER_STAGE = 4;
    localparam int NUM_STAGES      = VALUE_W / STEPS_PER_STAGE;

    localparam logic [CHAR_W-1:0] CHAR_BASE = 6'h30;
    localparam logic [3:0]        ADD_LIMIT = 4'd5;
    localparam logic [3:0]        ADD_FIX   = 4'd3;

    typedef logic [BCD_W-1:0]   t_bcd;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [IDX_W-1:0]   t_idx;

    // Partial conversion: decimal digits built so far and binary bits still to shift in.
    typedef struct packed {
        t_bcd   bcd;
        t_value bin;
    } t_dab;

    // Finished conversion handed from the pipeline to the character serializer.
    typedef struct packed {
        logic valid;
        t_bcd bcd;
    } t_bcd_out;

    function automatic t_dab dabble_steps(input t_dab a);
        t_dab r;
        r = a;
        for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (r.bcd[d*4 +: 4] >= ADD_LIMIT) begin
                    r.bcd[d*4 +: 4] = r.bcd[d*4 +: 4] + ADD_FIX;
                end
            end
            r.bcd = {r.bcd[BCD_W-2:0], r.bin[VALUE_W-1]};
            r.bin = {r.bin[VALUE_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== rtl/b2da_dabble_pipe.sv =====
// Pipelined shift-and-add-3 converter from a 32-bit binary value to ten BCD digits.
module b2da_dabble_pipe (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  b2da_pkg::t_value        i_value,
    output b2da_pkg::t_bcd_out      o_out,
    input  logic                    i_take
);

    logic             r_valid [b2da_pkg::NUM_STAGES];
    b2da_pkg::t_dab   r_dab   [b2da_pkg::NUM_STAGES];
    b2da_pkg::t_dab   n_dab   [b2da_pkg::NUM_STAGES];
    logic             n_valid [b2da_pkg::NUM_STAGES];
    logic             w_adv   [b2da_pkg::NUM_STAGES];

    // A stage moves when it is empty or when the stage after it moves too.
    always_comb begin
        for (int s = b2da_pkg::NUM_STAGES - 1; s >= 0; s--) begin
            if (s == b2da_pkg::NUM_STAGES - 1) begin
                w_adv[s] = !r_valid[s] || i_take;
            end else begin
                w_adv[s] = !r_valid[s] || w_adv[s+1];
            end
        end
    end

    always_comb begin
        for (int s = 0; s < b2da_pkg::NUM_STAGES; s++) begin
            if (s == 0) begin
                n_valid[s] = i_valid;
                n_dab[s]   = b2da_pkg::dabble_steps('{bcd: '0, bin: i_value});
            end else begin
                n_valid[s] = r_valid[s-1];
                n_dab[s]   = b2da_pkg::dabble_steps(r_dab[s-1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < b2da_pkg::NUM_STAGES; s++) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (w_adv[s]) begin
                r_valid[s] <= n_valid[s];
            end
            if (w_adv[s]) begin
                r_dab[s] <= n_dab[s];
            end
        end
    end

    assign o_ready     = w_adv[0];
    assign o_out.valid = r_valid[b2da_pkg::NUM_STAGES-1];
    assign o_out.bcd   = r_dab[b2da_pkg::NUM_STAGES-1].bcd;

endmodule

// ===== rtl/binary_to_decimal_ascii.sv =====
// Top level: converts 32-bit values to decimal ASCII digit requests, most significant first.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------
//  input   | in        | i_valid / o_ready  | i_value[31:0]
//  output  | out       | o_valid / i_ready  | o_digit_char[5:0], o_last_digit
//
// An eight-stage shift-and-add-3 pipeline converts one value per cycle while it is not backed up;
// a value passes through the stages in order and is then loaded into the serializer.
// The serializer emits one character per cycle while i_ready is high, so each value gives
// as many characters as it has digits (1 to 10), and that serializer sets the sustained rate.
// Synchronous active-low reset clears every valid bit; data registers keep their contents.
// A stalled output holds its character and backs the pipeline up without loss.
module binary_to_decimal_ascii (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [b2da_pkg::VALUE_W-1:0]   i_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [b2da_pkg::CHAR_W-1:0]    o_digit_char,
    output logic                           o_last_digit
);

    b2da_pkg::t_bcd_out w_pipe;
    logic               w_take;
    logic               w_done;
    b2da_pkg::t_idx     w_start;

    logic               r_busy;
    b2da_pkg::t_bcd     r_bcd;
    b2da_pkg::t_idx     r_idx;
    logic               n_busy;
    b2da_pkg::t_idx     n_idx;

    b2da_dabble_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_out   (w_pipe),
        .i_take  (w_take)
    );

    // The first digit shown is the highest nonzero one; zero shows its lowest digit.
    always_comb begin
        w_start = '0;
        for (int d = 0; d < b2da_pkg::DIGITS; d++) begin
            if (w_pipe.bcd[d*4 +: 4] != 4'd0) begin
                w_start = b2da_pkg::IDX_W'(d);
            end
        end
    end

    assign w_done = r_busy && i_ready && (r_idx == '0);
    assign w_take = w_pipe.valid && (!r_busy || w_done);

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (w_take) begin
            n_busy = 1'b1;
            n_idx  = w_start;
        end else if (w_done) begin
            n_busy = 1'b0;
        end else if (r_busy && i_ready) begin
            n_idx = r_idx - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_idx <= n_idx;
        if (w_take) begin
            r_bcd <= w_pipe.bcd;
        end
    end

    assign o_valid      = r_busy;
    assign o_digit_char = b2da_pkg::CHAR_BASE + {2'b00, r_bcd[r_idx*4 +: 4]};
    assign o_last_digit = (r_idx == '0);

endmodule

// ===== bench/binary_to_decimal_ascii_tb.sv =====
// Self-checking testbench for the binary to decimal ASCII converter.
module binary_to_decimal_ascii_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 410;
    localparam int HOLD_AT      = 140;
    localparam int DRAIN_AT     = 300;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        logic [b2da_pkg::CHAR_W-1:0] digit_char;
        logic                        last_digit;
    } t_digit_request;

    // Expands each accepted value into its decimal characters and checks them in order.
    class digit_scoreboard;
        localparam int DEC_RADIX = 10;

        t_digit_request expected_chars[$];
        int             values_noted;
        int             chars_checked;
        int             errors;

        function void note_value(b2da_pkg::t_value value);
            b2da_pkg::t_value rest;
            logic [3:0]       digits[$];
            t_digit_request   req;
            rest = value;
            do begin
                digits.push_front(4'(rest % DEC_RADIX));
                rest = rest / DEC_RADIX;
            end while (rest != 0);
            foreach (digits[k]) begin
                req.digit_char = b2da_pkg::CHAR_BASE + b2da_pkg::CHAR_W'(digits[k]);
                req.last_digit = (k == digits.size() - 1);
                expected_chars.push_back(req);
            end
            values_noted++;
        endfunction

        function void check_char(logic [b2da_pkg::CHAR_W-1:0] digit_char, logic last_digit);
            t_digit_request req;
            if (expected_chars.size() == 0) begin
                $error("unexpected character request: digit_char %0d last_digit %0d",
                       digit_char, last_digit);
                errors++;
            end else begin
                req = expected_chars.pop_front();
                if (digit_char !== req.digit_char) begin
                    $error("digit_char: expected %0d, actual %0d", req.digit_char, digit_char);
                    errors++;
                end
                if (last_digit !== req.last_digit) begin
                    $error("last_digit: expected %0d, actual %0d", req.last_digit, last_digit);
                    errors++;
                end
                chars_checked++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [b2da_pkg::VALUE_W-1:0]  i_value = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [b2da_pkg::CHAR_W-1:0]   o_digit_char;
    logic                          o_last_digit;

    int                  hold_req_cnt = 0;
    int                  idle_cycles  = 0;
    digit_scoreboard     sb = new();

    binary_to_decimal_ascii dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Offers one value and returns at the edge where the request is taken.
    task automatic send_value(input b2da_pkg::t_value value);
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_value(value);
    endtask

    // Drops valid and waits until every outstanding character has come out.
    task automatic drain_output();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Mixes short numbers, values around digit-count boundaries, values near the maximum and random-width values.
    function automatic b2da_pkg::t_value random_value();
        int               kind;
        int               nbits;
        b2da_pkg::t_value power;
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                return '1 - b2da_pkg::t_value'($urandom_range(0, 5));
            end
            1, 2: begin
                return b2da_pkg::t_value'($urandom_range(0, 99));
            end
            3, 4: begin
                power = 1;
                repeat ($urandom_range(0, 9)) power = power * 10;
                return power + b2da_pkg::t_value'($urandom_range(0, 2)) - 1;
            end
            default: begin
                nbits = $urandom_range(1, 32);
                return $urandom & b2da_pkg::t_value'((64'd1 << nbits) - 1);
            end
        endcase
    endfunction

    // Checks every character request taken by the receiver.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_char(o_digit_char, o_last_digit);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d cycles without a handshake", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random ready patterns in segments, plus one long hold-off on request.
    initial begin : receiver
        int hold_seen;
        int hold_left;
        int seg_left;
        int mode;
        hold_seen = 0;
        hold_left = 0;
        seg_left  = 0;
        mode      = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req_cnt != hold_seen) begin
                hold_seen = hold_req_cnt;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(8, 80);
                end
                seg_left--;
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= ($urandom_range(0, 3) != 0);
                    2:       i_ready <= 1'($urandom_range(0, 1));
                    default: i_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        b2da_pkg::t_value directed[$];
        int               burst_left;
        int               gap;
        directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
                     32'd65535, 32'd65536, 32'd999999999, 32'd1000000000,
                     32'd1000000001, 32'd2147483647, 32'd2147483648, 32'd4000000000,
                     32'd4294967290, 32'd4294967294, 32'd4294967295,
                     32'hAAAAAAAA, 32'h55555555};
        burst_left = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Back to back edge values, then let the pipeline empty out.
        foreach (directed[k]) send_value(directed[k]);
        drain_output();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT) begin
                // Keep offering while the output is held off so the block backs up.
                hold_req_cnt <= hold_req_cnt + 1;
                burst_left = 60;
            end
            if (n == DRAIN_AT) begin
                drain_output();
            end else if (burst_left == 0) begin
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    i_value <= $urandom;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            send_value(random_value());
            if (burst_left > 0) burst_left--;
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $error("%0d expected character requests never arrived", sb.pending());
            sb.errors++;
        end
        $display("Converted %0d values into %0d checked digit characters,", sb.values_noted,
                 sb.chars_checked);
        $display("with random bursts, output stalls, a long hold-off and full drains.");
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
